/* sv/ipv4p_pkg.sv */
`timescale 1ns / 1ps

package ipv4p_pkg;

    // Parse modes; codes 6 and 7 are unused and behave as start
    typedef enum logic [2:0] {
        MODE_START = 3'd0,
        MODE_ZERO  = 3'd1,
        MODE_ZEROX = 3'd2,
        MODE_HEX   = 3'd3,
        MODE_QUAD  = 3'd4,
        MODE_DEC   = 3'd5
    } mode_t;

    localparam logic [2:0] ST_RUN    = 3'd0;
    localparam logic [2:0] ST_DONE   = 3'd1;
    localparam logic [2:0] ST_EMPTY  = 3'd2;
    localparam logic [2:0] ST_SYNTAX = 3'd3;
    localparam logic [2:0] ST_OVER   = 3'd4;

    localparam logic [7:0]  CHAR_NUL  = 8'h00;
    localparam logic [7:0]  CHAR_ZERO = 8'h30;
    localparam logic [7:0]  CHAR_X    = 8'h78;
    localparam logic [7:0]  CHAR_DOT  = 8'h2e;
    localparam logic [11:0] OCTET_MAX = 12'h0ff;

    typedef struct packed {
        logic       digit;
        logic       space;
        logic       punct;
        logic       term;
        logic       hex_ok;
        logic [3:0] hex_val;
    } char_class_t;

    typedef struct packed {
        mode_t       mode;
        logic [1:0]  octet_idx;
        logic [11:0] cur_octet;
        logic [31:0] acc;
        logic        prev_zero;
    } parse_state_t;

    localparam parse_state_t STATE_CLEAR = '{
        mode:      MODE_START,
        octet_idx: 2'd0,
        cur_octet: 12'd0,
        acc:       32'd0,
        prev_zero: 1'b0
    };

endpackage

/* sv/ipv4_text_address_parser.sv */
`timescale 1ns / 1ps
// A character word is registered in the input stage, its result word in the
// result stage. Throughput: one word per cycle unless out_ready holds it off;
// the state loop closes through one compare-and-add step between the stages.
// Reset: rst_n asynchronous, active low; clears both stages and puts the
// parser in start mode with an empty accumulator.

module ipv4_text_address_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_code,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] address
);

    // Input stage: hold one character word
    logic       in_vld_reg;
    logic [7:0] char_reg;

    // Parse state, advanced once per word moved into the result stage
    ipv4p_pkg::parse_state_t state_reg;
    ipv4p_pkg::parse_state_t state_next;

    // Result stage
    logic        out_vld_reg;
    logic [2:0]  status_reg;
    logic [31:0] address_reg;
    logic [2:0]  status_next;
    logic [31:0] address_next;

    ipv4p_pkg::char_class_t cls;
    logic advance;

    // Advance a word when the result stage is empty or is being drained;
    // accept a fresh word whenever the input stage frees up in this cycle.
    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    ipv4p_class u_class (
        .char_code (char_reg),
        .cls       (cls)
    );

    ipv4p_step u_step (
        .char_code  (char_reg),
        .cls        (cls),
        .state      (state_reg),
        .state_next (state_next),
        .status     (status_next),
        .address    (address_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg   <= ipv4p_pkg::STATE_CLEAR;
        end else begin
            if (in_ready) begin
                in_vld_reg <= in_valid;
            end
            if (advance) begin
                out_vld_reg <= 1'b1;
                state_reg   <= state_next;
            end else if (out_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers: load only, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            char_reg <= char_code;
        end
        if (advance) begin
            status_reg  <= status_next;
            address_reg <= address_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign status    = status_reg;
    assign address   = address_reg;

`ifndef ASSERT_OFF
    // A result other than done must carry a zero address
    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && (status_reg != ipv4p_pkg::ST_DONE) |-> address_reg == 32'd0)
        else $error("address not zero on a non-done result");

    // Status codes above overflow are never produced
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> status_reg <= ipv4p_pkg::ST_OVER)
        else $error("status code out of range");

    // A final status restarts the parse
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (status_next != ipv4p_pkg::ST_RUN)
        |=> state_reg.mode == ipv4p_pkg::MODE_START && state_reg.acc == 32'd0)
        else $error("parser not restarted after final status");

    // Dots are counted only in dotted-quad mode
    a_idx_quad: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.mode != ipv4p_pkg::MODE_QUAD |-> state_reg.octet_idx == 2'd0)
        else $error("octet index set outside dotted-quad mode");

    // Back-pressure only when both stages are full and the output stalls
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> in_vld_reg && out_vld_reg && !out_ready)
        else $error("input stalled without cause");
`endif

endmodule

/* sv/ipv4p_class.sv */
`timescale 1ns / 1ps

module ipv4p_class (
    input  logic [7:0]             char_code,
    output ipv4p_pkg::char_class_t cls
);

    logic is_lower;
    logic is_upper;

    assign is_lower = (char_code >= 8'h61) && (char_code <= 8'h66);
    assign is_upper = (char_code >= 8'h41) && (char_code <= 8'h46);

    always_comb
    begin
        cls = '0;
        case (char_code) inside
            [8'd9:8'd13], 8'd32:
                cls.space = 1'b1;
            [8'd33:8'd47], [8'd58:8'd64], [8'd91:8'd96], [8'd123:8'd126]:
                cls.punct = 1'b1;
            default:
                ;
        endcase
        cls.digit  = (char_code >= 8'h30) && (char_code <= 8'h39);
        cls.term   = (char_code == ipv4p_pkg::CHAR_NUL) || cls.space || cls.punct;
        cls.hex_ok = cls.digit || is_lower || is_upper;
        // letters a-f and A-F share the low nibble 1..6
        cls.hex_val = cls.digit ? char_code[3:0] : (char_code[3:0] + 4'd9);
    end

endmodule

/* sv/ipv4p_step.sv */
`timescale 1ns / 1ps

module ipv4p_step (
    input  logic [7:0]              char_code,
    input  ipv4p_pkg::char_class_t  cls,
    input  ipv4p_pkg::parse_state_t state,
    output ipv4p_pkg::parse_state_t state_next,
    output logic [2:0]              status,
    output logic [31:0]             address
);

    logic [35:0] hex_x;
    logic [35:0] dec_x;
    logic [15:0] oct_x;
    logic [11:0] oct_new;
    logic [31:0] quad_addr;
    logic [31:0] addr_raw;
    logic        is_zero;
    logic        is_dot;
    ipv4p_pkg::parse_state_t nxt;

    assign is_zero   = (char_code == ipv4p_pkg::CHAR_ZERO);
    assign is_dot    = (char_code == ipv4p_pkg::CHAR_DOT);
    assign hex_x     = {state.acc, 4'b0000} + {32'd0, cls.hex_val};
    assign dec_x     = {1'b0, state.acc, 3'b000} + {3'b000, state.acc, 1'b0}
                     + {32'd0, char_code[3:0]};
    assign oct_x     = {1'b0, state.cur_octet, 3'b000} + {3'b000, state.cur_octet, 1'b0}
                     + {12'd0, char_code[3:0]};
    assign oct_new   = oct_x[11:0];
    assign quad_addr = (state.acc << 8) | {20'd0, state.cur_octet};

    always_comb
    begin
        nxt      = state;
        status   = ipv4p_pkg::ST_RUN;
        addr_raw = 32'd0;
        unique case (state.mode)
            ipv4p_pkg::MODE_ZERO:
            begin
                if (char_code == ipv4p_pkg::CHAR_X) begin
                    nxt.mode = ipv4p_pkg::MODE_ZEROX;
                end else if (is_dot) begin
                    nxt.mode      = ipv4p_pkg::MODE_QUAD;
                    nxt.acc       = 32'd0;
                    nxt.cur_octet = 12'd0;
                    nxt.octet_idx = 2'd1;
                end else if (cls.term) begin
                    status = ipv4p_pkg::ST_DONE;
                end else begin
                    status = ipv4p_pkg::ST_SYNTAX;
                end
            end
            ipv4p_pkg::MODE_ZEROX:
            begin
                if (cls.hex_ok) begin
                    nxt.acc  = {28'd0, cls.hex_val};
                    nxt.mode = ipv4p_pkg::MODE_HEX;
                end else begin
                    status = ipv4p_pkg::ST_SYNTAX;
                end
            end
            ipv4p_pkg::MODE_HEX:
            begin
                if (char_code == ipv4p_pkg::CHAR_NUL) begin
                    status   = ipv4p_pkg::ST_DONE;
                    addr_raw = state.acc;
                end else if (cls.hex_ok) begin
                    if (hex_x[35:32] != 4'd0) begin
                        status = ipv4p_pkg::ST_OVER;
                    end else begin
                        nxt.acc = hex_x[31:0];
                    end
                end else if (cls.term) begin
                    status   = ipv4p_pkg::ST_DONE;
                    addr_raw = state.acc;
                end else begin
                    status = ipv4p_pkg::ST_SYNTAX;
                end
            end
            ipv4p_pkg::MODE_QUAD:
            begin
                if (cls.digit) begin
                    if (state.cur_octet == 12'd0 && state.prev_zero) begin
                        status = ipv4p_pkg::ST_SYNTAX;
                    end else begin
                        nxt.cur_octet = oct_new;
                        if (oct_new > ipv4p_pkg::OCTET_MAX) begin
                            if (state.octet_idx == 2'd0) begin
                                nxt.mode = ipv4p_pkg::MODE_DEC;
                                nxt.acc  = {20'd0, oct_new};
                            end else begin
                                status = ipv4p_pkg::ST_SYNTAX;
                            end
                        end
                    end
                end else if (is_dot) begin
                    if (state.octet_idx == 2'd3) begin
                        status   = ipv4p_pkg::ST_DONE;
                        addr_raw = quad_addr;
                    end else begin
                        nxt.acc       = {8'd0, quad_addr[23:0]};
                        nxt.cur_octet = 12'd0;
                        nxt.octet_idx = state.octet_idx + 2'd1;
                    end
                end else if (cls.term && state.octet_idx == 2'd0) begin
                    status   = ipv4p_pkg::ST_DONE;
                    addr_raw = {20'd0, state.cur_octet};
                end else if (cls.term && state.octet_idx == 2'd3) begin
                    status   = ipv4p_pkg::ST_DONE;
                    addr_raw = quad_addr;
                end else begin
                    status = ipv4p_pkg::ST_SYNTAX;
                end
            end
            ipv4p_pkg::MODE_DEC:
            begin
                if (cls.term) begin
                    status   = ipv4p_pkg::ST_DONE;
                    addr_raw = state.acc;
                end else if (cls.digit) begin
                    if (dec_x[35:32] != 4'd0) begin
                        status = ipv4p_pkg::ST_OVER;
                    end else begin
                        nxt.acc = dec_x[31:0];
                    end
                end else begin
                    status = ipv4p_pkg::ST_SYNTAX;
                end
            end
            default:
            begin
                if (char_code == ipv4p_pkg::CHAR_NUL) begin
                    status = ipv4p_pkg::ST_EMPTY;
                end else if (cls.space) begin
                    // skip leading whitespace
                end else if (is_zero) begin
                    nxt.mode = ipv4p_pkg::MODE_ZERO;
                end else if (cls.digit) begin
                    nxt.mode      = ipv4p_pkg::MODE_QUAD;
                    nxt.octet_idx = 2'd0;
                    nxt.acc       = 32'd0;
                    nxt.cur_octet = {8'd0, char_code[3:0]};
                end else begin
                    status = ipv4p_pkg::ST_SYNTAX;
                end
            end
        endcase

        if (status != ipv4p_pkg::ST_RUN) begin
            state_next = ipv4p_pkg::STATE_CLEAR;
        end else begin
            state_next           = nxt;
            state_next.prev_zero = is_zero;
        end
        address = (status == ipv4p_pkg::ST_DONE) ? addr_raw : 32'd0;
    end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;

    // One result word as the parser reports it
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] address;
    } parse_result_t;

    // One row of the directed text; the result is typed in only where obvious
    typedef struct {
        logic [7:0]    ch;
        bit            typed;
        parse_result_t res;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  char_code;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [31:0] address;

    // Predictor copy of the parse state
    ipv4p_pkg::mode_t p_mode;
    logic [1:0]       p_index;
    logic [11:0]      p_octet;
    logic [31:0]      p_acc;
    logic             p_zero;

    parse_result_t awaited_results[$];
    stim_row_t     stimulus_rows[$];
    logic [7:0]    text_q[$];
    int unsigned   chars_sent = 0;
    int unsigned   mismatches = 0;
    bit            steady_source = 1'b0;
    bit            sink_held = 1'b0;

    ipv4_text_address_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_code (char_code),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .address   (address)
    );

    always #1 clk = ~clk;

    // Character classes, C locale
    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_space(input logic [7:0] c);
        return (c >= 8'd9 && c <= 8'd13) || c == 8'd32;
    endfunction

    function automatic bit is_term(input logic [7:0] c);
        return c == ipv4p_pkg::CHAR_NUL || is_space(c) ||
               (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
               (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
    endfunction

    function automatic int hex_digit(input logic [7:0] c);
        if (is_digit(c)) return int'(c[3:0]);
        // letters a-f and A-F share the low nibble 1..6
        if (c >= "a" && c <= "f") return int'(c[3:0]) + 9;
        if (c >= "A" && c <= "F") return int'(c[3:0]) + 9;
        return -1;
    endfunction

    function automatic void clear_parse();
        p_mode  = ipv4p_pkg::MODE_START;
        p_index = 2'd0;
        p_octet = 12'd0;
        p_acc   = 32'd0;
        p_zero  = 1'b0;
    endfunction

    // Advance the predicted parse by one character and return its result word
    function automatic parse_result_t parse_char(input logic [7:0] c);
        parse_result_t r;
        int            h;
        logic [35:0]   wide;
        logic [15:0]   nxt;
        r.status  = ipv4p_pkg::ST_RUN;
        r.address = 32'd0;
        h = hex_digit(c);
        case (p_mode)
            ipv4p_pkg::MODE_ZERO:
            begin
                if (c == ipv4p_pkg::CHAR_X)
                begin
                    p_mode = ipv4p_pkg::MODE_ZEROX;
                end
                else if (c == ipv4p_pkg::CHAR_DOT)
                begin
                    p_mode  = ipv4p_pkg::MODE_QUAD;
                    p_acc   = 32'd0;
                    p_octet = 12'd0;
                    p_index = 2'd1;
                end
                else if (is_term(c))
                begin
                    r.status = ipv4p_pkg::ST_DONE;
                end
                else
                begin
                    r.status = ipv4p_pkg::ST_SYNTAX;
                end
            end
            ipv4p_pkg::MODE_ZEROX:
            begin
                if (h >= 0)
                begin
                    p_acc  = {28'd0, h[3:0]};
                    p_mode = ipv4p_pkg::MODE_HEX;
                end
                else
                begin
                    r.status = ipv4p_pkg::ST_SYNTAX;
                end
            end
            ipv4p_pkg::MODE_HEX:
            begin
                if (c == ipv4p_pkg::CHAR_NUL)
                begin
                    r.status  = ipv4p_pkg::ST_DONE;
                    r.address = p_acc;
                end
                else if (h >= 0)
                begin
                    wide = {4'd0, p_acc} * 36'd16 + {32'd0, h[3:0]};
                    if (wide > 36'hffff_ffff) r.status = ipv4p_pkg::ST_OVER;
                    else p_acc = wide[31:0];
                end
                else if (is_term(c))
                begin
                    r.status  = ipv4p_pkg::ST_DONE;
                    r.address = p_acc;
                end
                else
                begin
                    r.status = ipv4p_pkg::ST_SYNTAX;
                end
            end
            ipv4p_pkg::MODE_QUAD:
            begin
                if (is_digit(c))
                begin
                    if (p_octet == 12'd0 && p_zero)
                    begin
                        r.status = ipv4p_pkg::ST_SYNTAX;
                    end
                    else
                    begin
                        nxt     = {4'd0, p_octet} * 16'd10
                                + {8'd0, c - ipv4p_pkg::CHAR_ZERO};
                        p_octet = nxt[11:0];
                        if (p_octet > ipv4p_pkg::OCTET_MAX)
                        begin
                            if (p_index == 2'd0)
                            begin
                                p_mode = ipv4p_pkg::MODE_DEC;
                                p_acc  = {20'd0, p_octet};
                            end
                            else
                            begin
                                r.status = ipv4p_pkg::ST_SYNTAX;
                            end
                        end
                    end
                end
                else if (c == ipv4p_pkg::CHAR_DOT)
                begin
                    if (p_index == 2'd3)
                    begin
                        r.status  = ipv4p_pkg::ST_DONE;
                        r.address = (p_acc << 8) | {20'd0, p_octet};
                    end
                    else
                    begin
                        p_acc   = ((p_acc << 8) | {20'd0, p_octet}) & 32'h00ff_ffff;
                        p_octet = 12'd0;
                        p_index = p_index + 2'd1;
                    end
                end
                else if (is_term(c) && p_index == 2'd0)
                begin
                    r.status  = ipv4p_pkg::ST_DONE;
                    r.address = {20'd0, p_octet};
                end
                else if (is_term(c) && p_index == 2'd3)
                begin
                    r.status  = ipv4p_pkg::ST_DONE;
                    r.address = (p_acc << 8) | {20'd0, p_octet};
                end
                else
                begin
                    r.status = ipv4p_pkg::ST_SYNTAX;
                end
            end
            ipv4p_pkg::MODE_DEC:
            begin
                if (is_term(c))
                begin
                    r.status  = ipv4p_pkg::ST_DONE;
                    r.address = p_acc;
                end
                else if (is_digit(c))
                begin
                    wide = {4'd0, p_acc} * 36'd10
                         + {28'd0, c - ipv4p_pkg::CHAR_ZERO};
                    if (wide > 36'hffff_ffff) r.status = ipv4p_pkg::ST_OVER;
                    else p_acc = wide[31:0];
                end
                else
                begin
                    r.status = ipv4p_pkg::ST_SYNTAX;
                end
            end
            default:
            begin
                // start mode; spare mode codes behave the same way
                if (c == ipv4p_pkg::CHAR_NUL)
                begin
                    r.status = ipv4p_pkg::ST_EMPTY;
                end
                else if (is_space(c))
                begin
                    // skip leading whitespace
                end
                else if (c == ipv4p_pkg::CHAR_ZERO)
                begin
                    p_mode = ipv4p_pkg::MODE_ZERO;
                end
                else if (is_digit(c))
                begin
                    p_mode  = ipv4p_pkg::MODE_QUAD;
                    p_index = 2'd0;
                    p_acc   = 32'd0;
                    p_octet = {4'd0, c - ipv4p_pkg::CHAR_ZERO};
                end
                else
                begin
                    r.status = ipv4p_pkg::ST_SYNTAX;
                end
            end
        endcase
        if (r.status != ipv4p_pkg::ST_RUN) clear_parse();
        else p_zero = (c == ipv4p_pkg::CHAR_ZERO);
        if (r.status != ipv4p_pkg::ST_DONE) r.address = 32'd0;
        return r;
    endfunction

    function automatic void add_row(input logic [7:0] ch, input bit typed,
                                    input logic [2:0] st, input logic [31:0] addr);
        stim_row_t row;
        row.ch          = ch;
        row.typed       = typed;
        row.res.status  = st;
        row.res.address = addr;
        stimulus_rows.push_back(row);
    endfunction

    // Sender gap: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady_source || sink_held) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic logic [7:0] pick_space();
        logic [7:0] v;
        if ($urandom_range(0, 1) == 0) v = 8'd32;
        else v = 8'($urandom_range(9, 13));
        return v;
    endfunction

    // Character after a well-formed field: mostly a terminator, sometimes not
    function automatic logic [7:0] pick_end();
        logic [7:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = ipv4p_pkg::CHAR_NUL;
            4, 5:       v = pick_space();
            6, 7:
            begin
                do v = 8'($urandom_range(33, 126)); while (!is_term(v));
            end
            8:          v = ipv4p_pkg::CHAR_DOT;
            default:    v = 8'($urandom_range(0, 255));
        endcase
        return v;
    endfunction

    task automatic push_decimal(input longint unsigned v);
        logic [7:0] digits[$];
        do
        begin
            digits.push_front(ipv4p_pkg::CHAR_ZERO + 8'(v % 10));
            v = v / 10;
        end
        while (v != 0);
        foreach (digits[i]) text_q.push_back(digits[i]);
    endtask

    // Build one text: mostly well-formed addresses with random content
    task automatic build_sequence();
        int unsigned     kind;
        int unsigned     fields;
        int unsigned     n;
        longint unsigned v;
        string           hexchars;
        hexchars = "0123456789abcdefABCDEF";
        steady_source = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) text_q.push_back(pick_space());
        kind = $urandom_range(0, 99);
        if (kind < 40)
        begin
            // dotted quad; now and then short, long, or with a bad octet
            n = $urandom_range(0, 9);
            if (n == 6) fields = 5;
            else if (n == 7) fields = $urandom_range(1, 3);
            else fields = 4;
            for (int i = 0; i < fields; i++)
            begin
                if (i != 0) text_q.push_back(ipv4p_pkg::CHAR_DOT);
                n = $urandom_range(0, 19);
                if (n == 0 && i == 3)
                begin
                    // leave the last octet out
                end
                else if (n == 1)
                begin
                    text_q.push_back(ipv4p_pkg::CHAR_ZERO);
                    push_decimal(64'($urandom_range(0, 255)));
                end
                else if (n == 2)
                begin
                    push_decimal(64'($urandom_range(256, 999)));
                end
                else if (n < 6)
                begin
                    push_decimal(64'($urandom_range(0, 9)));
                end
                else
                begin
                    push_decimal(64'($urandom_range(0, 255)));
                end
            end
        end
        else if (kind < 60)
        begin
            // hex; nine digits can run past 32 bits
            text_q.push_back(ipv4p_pkg::CHAR_ZERO);
            text_q.push_back(ipv4p_pkg::CHAR_X);
            n = $urandom_range(0, 19);
            if (n == 0) n = 0;
            else if (n < 4) n = 9;
            else n = $urandom_range(1, 8);
            repeat (n) text_q.push_back(hexchars[$urandom_range(0, 21)]);
        end
        else if (kind < 78)
        begin
            // plain decimal; the top range runs past 32 bits
            if ($urandom_range(0, 3) == 0) v = {$urandom_range(0, 3), $urandom};
            else v = 64'($urandom_range(256, 32'hffff_ffff));
            push_decimal(v);
        end
        else if (kind < 88)
        begin
            text_q.push_back(ipv4p_pkg::CHAR_ZERO);
        end
        else
        begin
            repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
        end
        if (kind < 88) text_q.push_back(pick_end());
        // corrupt one character now and then
        if ($urandom_range(0, 9) == 0)
            text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
    endtask

    // Offer one character word; entered and left at a falling edge
    task automatic send_char(input logic [7:0] c, input bit typed,
                             input parse_result_t typed_res);
        int unsigned   gap;
        parse_result_t res;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid  <= 1'b0;
            char_code <= 8'($urandom_range(0, 255));
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        res = parse_char(c);
        if (typed) res = typed_res;
        awaited_results.push_back(res);
        chars_sent++;
        @(negedge clk);
    endtask

    initial
    begin : source
        int unsigned spin;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        char_code = 8'd0;
        clear_parse();

        // Directed text: end of string, extremes and several syntax error paths
        add_row(ipv4p_pkg::CHAR_NUL,  1, ipv4p_pkg::ST_EMPTY,  32'd0);
        add_row(8'hff,                1, ipv4p_pkg::ST_SYNTAX, 32'd0);
        add_row(" ",                  1, ipv4p_pkg::ST_RUN,    32'd0);
        add_row(ipv4p_pkg::CHAR_ZERO, 0, ipv4p_pkg::ST_RUN,    32'd0);
        add_row(ipv4p_pkg::CHAR_NUL,  1, ipv4p_pkg::ST_DONE,   32'd0);
        add_row(ipv4p_pkg::CHAR_ZERO, 0, ipv4p_pkg::ST_RUN,    32'd0);
        add_row("a",                  1, ipv4p_pkg::ST_SYNTAX, 32'd0);
        add_row(ipv4p_pkg::CHAR_ZERO, 0, ipv4p_pkg::ST_RUN,    32'd0);
        add_row(ipv4p_pkg::CHAR_X,    0, ipv4p_pkg::ST_RUN,    32'd0);
        add_row(ipv4p_pkg::CHAR_NUL,  1, ipv4p_pkg::ST_SYNTAX, 32'd0);
        add_row("1",                  0, ipv4p_pkg::ST_RUN,    32'd0);
        add_row(ipv4p_pkg::CHAR_DOT,  0, ipv4p_pkg::ST_RUN,    32'd0);
        add_row(ipv4p_pkg::CHAR_ZERO, 0, ipv4p_pkg::ST_RUN,    32'd0);
        add_row("1",                  1, ipv4p_pkg::ST_SYNTAX, 32'd0);
        add_row("7",                  0, ipv4p_pkg::ST_RUN,    32'd0);
        add_row(ipv4p_pkg::CHAR_DOT,  0, ipv4p_pkg::ST_RUN,    32'd0);
        add_row("2",                  0, ipv4p_pkg::ST_RUN,    32'd0);
        add_row("5",                  0, ipv4p_pkg::ST_RUN,    32'd0);
        add_row("6",                  1, ipv4p_pkg::ST_SYNTAX, 32'd0);
        add_row("1",                  0, ipv4p_pkg::ST_RUN,    32'd0);
        add_row(ipv4p_pkg::CHAR_DOT,  0, ipv4p_pkg::ST_RUN,    32'd0);
        add_row("2",                  0, ipv4p_pkg::ST_RUN,    32'd0);
        add_row(ipv4p_pkg::CHAR_NUL,  1, ipv4p_pkg::ST_SYNTAX, 32'd0);

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (stimulus_rows[i])
            send_char(stimulus_rows[i].ch, stimulus_rows[i].typed, stimulus_rows[i].res);

        while (chars_sent < 500)
        begin
            build_sequence();
            foreach (text_q[i]) send_char(text_q[i], 1'b0, '0);
            text_q.delete();
        end
        in_valid <= 1'b0;

        // Drain: wait for every awaited word, up to a bound
        spin = 0;
        while (awaited_results.size() != 0 && spin < 5000)
        begin
            @(posedge clk);
            spin++;
        end
        repeat (6) @(posedge clk);
        if (awaited_results.size() != 0)
        begin
            mismatches++;
            $display("%0t ns: expected %0d more result words, got none",
                     $time, awaited_results.size());
        end

        if (mismatches == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

    // Result side: random ready, plus one long hold-off to back the parser up
    initial
    begin : sink
        int unsigned r;
        int unsigned span;
        bit          held;
        held      = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!held && chars_sent >= 80)
            begin
                held      = 1'b1;
                sink_held = 1'b1;
                out_ready <= 1'b0;
                repeat (120) @(negedge clk);
                sink_held = 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                begin
                    out_ready <= 1'b1;
                    span = $urandom_range(1, 12);
                end
                else if (r < 70)
                begin
                    out_ready <= 1'b1;
                    span = $urandom_range(20, 60);
                end
                else
                begin
                    out_ready <= 1'b0;
                    span = (r < 95) ? $urandom_range(1, 3) : $urandom_range(5, 30);
                end
                repeat (span) @(negedge clk);
            end
        end
    end

    // Compare every accepted result word with the oldest awaited one
    always @(posedge clk)
    begin : result_check
        parse_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: expected no word, got status %0d address %h",
                         $time, status, address);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (status !== want.status || address !== want.address)
                begin
                    mismatches++;
                    $display({"%0t ns: expected status %0d address %h, ",
                              "got status %0d address %h"},
                             $time, want.status, want.address, status, address);
                end
            end
        end
    end

    initial
    begin : watchdog
        #1_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
